/* design/depth_tested_line_raster_unit_assert.svh */
// Assertion macros for the depth-tested line raster unit.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef DEPTH_TESTED_LINE_RASTER_UNIT_ASSERT_SVH
`define DEPTH_TESTED_LINE_RASTER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DTLR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DTLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dtlr_pkg.sv */
// Shared types and constants for the depth-tested line raster unit.
// No dependencies.
package dtlr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam int unsigned QW = 38;  // dividend width of the shared divider
  localparam logic [15:0] INV_MAX = 16'hFFFF;
  localparam logic [7:0]  ALPHA   = 8'hFF;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_DIV_D,
    ST_PIX, ST_INV, ST_READ, ST_WRITE, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DSEL_X, DSEL_Y, DSEL_D, DSEL_INV
  } dsel_e;

  // Controller to datapath.
  typedef struct packed {
    logic  clr_step;     // write one clearing entry
    logic  load;         // latch a start word
    logic  div_start;    // begin a division
    dsel_e div_sel;
    logic  div_store;    // store quotient for div_sel
    logic  pix_eval;     // compute address and flags
    logic  mem_read;
    logic  mem_write;    // read-modify-write commit
    logic  out_load;     // fill the output register
    logic  advance;      // step the position
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic div_done;
    logic n_zero;
    logic need_mem;      // on screen with negative depth
    logic active;        // points left
  } stat_t;

endpackage

/* design/dtlr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on dtlr_pkg.
module dtlr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dtlr_pkg::QW-1:0]   num_i,
  input  logic [dtlr_pkg::QW-1:0]   den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [dtlr_pkg::QW-1:0]   quo_o
);
  localparam int unsigned CW = $clog2(dtlr_pkg::QW + 1);

  logic [dtlr_pkg::QW-1:0] q_q, q_d, den_q, den_d;
  logic [dtlr_pkg::QW:0]   r_q, r_d, r_sh;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d = q_q; den_d = den_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    r_sh = {r_q[dtlr_pkg::QW-1:0], q_q[dtlr_pkg::QW-1]};
    if (start_i) begin
      q_d = num_i; den_d = den_i; r_d = '0;
      cnt_d = CW'(dtlr_pkg::QW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (r_sh >= {1'b0, den_q}) begin
        r_d = r_sh - {1'b0, den_q};
        q_d = {q_q[dtlr_pkg::QW-2:0], 1'b1};
      end else begin
        r_d = r_sh;
        q_d = {q_q[dtlr_pkg::QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; den_q <= den_d; r_q <= r_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

/* design/dtlr_datapath.sv */
// Datapath: line registers, shared divider, depth store and output register.
// Depends on dtlr_pkg and dtlr_div.
module dtlr_datapath #(
  parameter int unsigned SCREEN_WIDTH  = dtlr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = dtlr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtlr_pkg::ctrl_t   ctrl_i,
  output dtlr_pkg::stat_t   stat_o,
  input  logic [111:0]      s_tdata_i,
  output logic [55:0]       out_data_o,
  output logic [1:0]        out_user_o,
  output logic              out_last_o
);
  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned QW    = dtlr_pkg::QW;

  // Unpacked start fields.
  logic signed [13:0] sx, sy, ex, ey;
  logic signed [15:0] sd, ed;
  assign sx = s_tdata_i[13:0];
  assign sy = s_tdata_i[27:14];
  assign sd = s_tdata_i[43:28];
  assign ex = s_tdata_i[57:44];
  assign ey = s_tdata_i[71:58];
  assign ed = s_tdata_i[87:72];

  logic signed [14:0] dx_q, dy_q;
  logic signed [16:0] dd_q;
  logic        [14:0] n_q;
  logic [23:0] cur_x_q, cur_y_q, step_x_q, step_y_q, colour_q;
  logic [31:0] cur_d_q, step_d_q;
  logic [10:0] left_q;

  logic signed [14:0] dx, dy;
  logic signed [16:0] dd;
  logic [14:0] adx, ady;
  assign dx  = 15'(ex) - 15'(sx);
  assign dy  = 15'(ey) - 15'(sy);
  assign dd  = 17'(ed) - 17'(sd);
  assign adx = dx[14] ? 15'(-dx) : dx;
  assign ady = dy[14] ? 15'(-dy) : dy;

  // Divider operand selection: rounded step = (|num|*2 + n) / (2n).
  logic [QW-1:0] div_num, div_den, quo;
  logic          div_busy, div_done;
  logic [16:0]   amag;
  logic          neg_sel;
  logic [32:0]   mz_q;

  always_comb begin
    amag = '0; neg_sel = 1'b0;
    case (ctrl_i.div_sel)
      dtlr_pkg::DSEL_X: begin
        amag = 17'(dx_q[14] ? 15'(-dx_q) : dx_q); neg_sel = dx_q[14];
      end
      dtlr_pkg::DSEL_Y: begin
        amag = 17'(dy_q[14] ? 15'(-dy_q) : dy_q); neg_sel = dy_q[14];
      end
      dtlr_pkg::DSEL_D: begin
        amag = dd_q[16] ? 17'(-dd_q) : 17'(dd_q); neg_sel = dd_q[16];
      end
      default: begin
        amag = '0; neg_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctrl_i.div_sel)
      dtlr_pkg::DSEL_X, dtlr_pkg::DSEL_Y:
        div_num = (QW'(amag) << 14) + QW'(n_q);
      dtlr_pkg::DSEL_D:
        div_num = (QW'(amag) << 13) + QW'(n_q);
      default:
        div_num = QW'(1) << 32;
    endcase
    div_den = (ctrl_i.div_sel == dtlr_pkg::DSEL_INV) ? QW'(mz_q) : (QW'(n_q) << 1);
  end

  dtlr_div u_div (
    .clk_i, .rst_ni,
    .start_i (ctrl_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  logic [31:0] sq;
  assign sq = neg_sel ? 32'(-quo[31:0]) : quo[31:0];

  // Pixel evaluation.
  logic signed [10:0] px, py;
  assign px = 11'(signed'(cur_x_q) >>> 13);
  assign py = 11'(signed'(cur_y_q) >>> 13);

  logic on_q, need_q, we_q, last_q;
  logic [9:0] px_q, py_q;
  logic [AW-1:0] addr_q;
  logic [15:0] inv_q, rd_q;
  logic on_c;
  assign on_c = !px[10] && !py[10] &&
                (32'(px) < SCREEN_WIDTH) && (32'(py) < SCREEN_HEIGHT);

  // Depth store.
  logic [15:0] mem [DEPTH];
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_step) mem[clr_q] <= '0;
    else if (ctrl_i.mem_write && (inv_q >= rd_q)) mem[addr_q] <= inv_q;
    if (ctrl_i.mem_read) rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; left_q <= '0;
    end else begin
      if (ctrl_i.clr_step && clr_q != AW'(DEPTH - 1)) clr_q <= clr_q + 1'b1;
      if (ctrl_i.load)
        left_q <= 11'((({1'b0, adx > ady ? adx : ady}) + 16'd15) >> 4) + 11'd1;
      else if (ctrl_i.advance) left_q <= left_q - 11'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dx_q <= dx; dy_q <= dy; dd_q <= dd;
      n_q <= adx > ady ? adx : ady;
      cur_x_q <= {sx[13], sx, 9'd0};
      cur_y_q <= {sy[13], sy, 9'd0};
      cur_d_q <= {{8{sd[15]}}, sd, 8'd0};
      step_x_q <= '0; step_y_q <= '0; step_d_q <= '0;
      colour_q <= {s_tdata_i[95:88], s_tdata_i[103:96], s_tdata_i[111:104]};
    end
    if (ctrl_i.div_store) begin
      case (ctrl_i.div_sel)
        dtlr_pkg::DSEL_X: step_x_q <= sq[23:0];
        dtlr_pkg::DSEL_Y: step_y_q <= sq[23:0];
        dtlr_pkg::DSEL_D: step_d_q <= sq;
        default: inv_q <= (|quo[QW-1:16]) ? dtlr_pkg::INV_MAX : quo[15:0];
      endcase
    end
    if (ctrl_i.pix_eval) begin
      on_q   <= on_c;
      need_q <= on_c && cur_d_q[31];
      px_q   <= px[9:0];
      py_q   <= py[9:0];
      addr_q <= AW'(32'(py[9:0]) * SCREEN_WIDTH + 32'(px[9:0]));
      mz_q   <= 33'(-signed'(cur_d_q));
      last_q <= (left_q == 11'd1);
      we_q   <= 1'b0;
    end
    if (ctrl_i.mem_write) we_q <= (inv_q >= rd_q);
    if (ctrl_i.advance) begin
      cur_x_q <= cur_x_q + step_x_q;
      cur_y_q <= cur_y_q + step_y_q;
      cur_d_q <= cur_d_q + step_d_q;
    end
  end

  // Output word: x, y, colour; flags: write, off; last point.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_data_o <= {4'd0, dtlr_pkg::ALPHA, colour_q,
                     on_q ? py_q : 10'd0, on_q ? px_q : 10'd0};
      out_user_o <= {!on_q, we_q};
      out_last_o <= last_q;
    end
  end

  assign stat_o.clr_done = (clr_q == AW'(DEPTH - 1));
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign stat_o.n_zero   = (n_q == '0);
  assign stat_o.need_mem = need_q;
  assign stat_o.active   = (left_q != '0);
endmodule

/* design/dtlr_ctrl.sv */
// Controller state machine: clearing pass, step divisions and pixel sequence.
// Depends on dtlr_pkg and the assertion macro header.
`include "depth_tested_line_raster_unit_assert.svh"
module dtlr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic            s_action_i,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  dtlr_pkg::stat_t stat_i,
  output dtlr_pkg::ctrl_t ctrl_o
);
  dtlr_pkg::state_e st_q, st_d;
  logic vld_q, vld_d;
  logic acc;

  // A waiting result does not block the input; the pixel sequence stalls in ST_OUT.
  assign s_tready_o = (st_q == dtlr_pkg::ST_IDLE);
  assign acc = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = vld_q;

  always_comb begin
    st_d = st_q; vld_d = vld_q;
    ctrl_o = '0;
    ctrl_o.div_sel = dtlr_pkg::DSEL_X;
    if (vld_q && m_tready_i) vld_d = 1'b0;
    case (st_q)
      dtlr_pkg::ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_done) st_d = dtlr_pkg::ST_IDLE;
      end
      dtlr_pkg::ST_IDLE: begin
        if (acc) begin
          if (s_action_i == dtlr_pkg::ACT_START) begin
            ctrl_o.load = 1'b1; st_d = dtlr_pkg::ST_DIV_X;
          end else if (stat_i.active) begin
            st_d = dtlr_pkg::ST_PIX;
          end
        end
      end
      dtlr_pkg::ST_DIV_X, dtlr_pkg::ST_DIV_Y, dtlr_pkg::ST_DIV_D: begin
        ctrl_o.div_sel = (st_q == dtlr_pkg::ST_DIV_X) ? dtlr_pkg::DSEL_X :
                         (st_q == dtlr_pkg::ST_DIV_Y) ? dtlr_pkg::DSEL_Y : dtlr_pkg::DSEL_D;
        if (stat_i.n_zero) st_d = dtlr_pkg::ST_IDLE;
        else if (stat_i.div_done) begin
          ctrl_o.div_store = 1'b1;
          st_d = (st_q == dtlr_pkg::ST_DIV_X) ? dtlr_pkg::ST_DIV_Y :
                 (st_q == dtlr_pkg::ST_DIV_Y) ? dtlr_pkg::ST_DIV_D : dtlr_pkg::ST_IDLE;
        end else if (!stat_i.div_busy) ctrl_o.div_start = 1'b1;
      end
      dtlr_pkg::ST_PIX: begin
        ctrl_o.pix_eval = 1'b1; st_d = dtlr_pkg::ST_INV;
      end
      dtlr_pkg::ST_INV: begin
        ctrl_o.div_sel = dtlr_pkg::DSEL_INV;
        if (!stat_i.need_mem) st_d = dtlr_pkg::ST_OUT;
        else if (stat_i.div_done) begin
          ctrl_o.div_store = 1'b1; ctrl_o.mem_read = 1'b1; st_d = dtlr_pkg::ST_READ;
        end else if (!stat_i.div_busy) ctrl_o.div_start = 1'b1;
      end
      dtlr_pkg::ST_READ: st_d = dtlr_pkg::ST_WRITE;
      dtlr_pkg::ST_WRITE: begin
        ctrl_o.mem_write = 1'b1; st_d = dtlr_pkg::ST_OUT;
      end
      dtlr_pkg::ST_OUT: begin
        if (!vld_q) begin
          ctrl_o.out_load = 1'b1; ctrl_o.advance = 1'b1;
          vld_d = 1'b1; st_d = dtlr_pkg::ST_IDLE;
        end
      end
      default: st_d = dtlr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dtlr_pkg::ST_CLEAR; vld_q <= 1'b0;
    end else begin
      st_q <= st_d; vld_q <= vld_d;
    end
  end

  `DTLR_ASSERT_IMP(a_no_accept_clear, clk_i, rst_ni,
                   st_q == dtlr_pkg::ST_CLEAR, !s_tready_o, "accept during clear")
  `DTLR_ASSERT_IMP(a_write_excl, clk_i, rst_ni,
                   ctrl_o.mem_write, !ctrl_o.clr_step, "write during clear")
  `DTLR_ASSERT_NEXT(a_out_valid, clk_i, rst_ni,
                    ctrl_o.out_load, m_tvalid_o, "result lost")
  `DTLR_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni,
                   ctrl_o.out_load, !vld_q, "result overwritten")
endmodule

/* design/depth_tested_line_raster_unit.sv */
// Depth-tested DDA line rasterizer: a start word runs three step divisions one after another
// on a shared serial divider before the next word is taken; a zero-length line skips them.
// A tick word off screen or with non-negative depth skips the divider; otherwise it runs a
// reciprocal divide plus store read-modify-write; its result is valid after that.
// A result waits in the output register; the next pixel holds in ST_OUT until it is taken.
// After reset a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT entries precedes the first word.
module depth_tested_line_raster_unit #(
  parameter int unsigned SCREEN_WIDTH  = dtlr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = dtlr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // action
  input  logic         s_tuser_i,
  // start_x, start_y, start_depth, end_x, end_y, end_depth, red, green, blue
  input  logic [111:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // pixel_x, pixel_y, pixel_colour, zero fill
  output logic [55:0]  m_tdata_o,
  // write_enable, off_screen
  output logic [1:0]   m_tuser_o,
  output logic         m_tlast_o
);
  dtlr_pkg::ctrl_t ctrl;
  dtlr_pkg::stat_t stat;

  dtlr_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o,
    .s_action_i (s_tuser_i),
    .m_tvalid_o, .m_tready_i,
    .stat_i (stat), .ctrl_o (ctrl)
  );

  dtlr_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .ctrl_i (ctrl), .stat_o (stat),
    .s_tdata_i, .out_data_o (m_tdata_o), .out_user_o (m_tuser_o), .out_last_o (m_tlast_o)
  );
endmodule

/* tb/sv/tb_depth_tested_line_raster_unit.sv */
// Self-checking testbench for the depth-tested line raster unit: drives start and
// tick words, predicts every pixel word and its depth-store update, and checks them.
// Depends on dtlr_pkg and the depth_tested_line_raster_unit RTL.
`timescale 1ns / 1ps

module tb_depth_tested_line_raster_unit;

  localparam int unsigned SW = dtlr_pkg::SCREEN_WIDTH_DEF;
  localparam int unsigned SH = dtlr_pkg::SCREEN_HEIGHT_DEF;
  localparam int NUM_WORDS = 1900;

  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [31:0] colour;
    logic        we;
    logic        off;
    logic        last;
  } pixel_t;

  // Keeps its own copy of the line state and the inverse-depth store.
  class raster_scoreboard;
    logic [23:0] pos_x, pos_y, inc_x, inc_y, rgb;
    logic [31:0] pos_z, inc_z;
    int unsigned pts_left;
    logic [15:0] zbuf[SW*SH];
    pixel_t      pending_px[$];
    int          errors;
    int          lines, writes, offs, checked;

    function new();
      pos_x = '0; pos_y = '0; inc_x = '0; inc_y = '0; rgb = '0;
      pos_z = '0; inc_z = '0; pts_left = 0;
      errors = 0; lines = 0; writes = 0; offs = 0; checked = 0;
      foreach (zbuf[i]) zbuf[i] = '0;
    endfunction

    function longint div_half_away(longint num, longint den);
      longint a, q;
      a = (num < 0) ? -num : num;
      q = (a + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function longint pixel_floor(longint v);
      if (v >= 0) return v >>> 13;
      return -((-v + 8191) >>> 13);
    endfunction

    function void note_word(logic act, logic [111:0] d);
      longint sx, sy, sz, ex, ey, ez, dx, dy, dz, n, xx, yy, zz, inv, idx;
      bit     on, we;
      pixel_t p;
      if (act == dtlr_pkg::ACT_START) begin
        sx = longint'($signed(d[13:0]));  sy = longint'($signed(d[27:14]));
        sz = longint'($signed(d[43:28])); ex = longint'($signed(d[57:44]));
        ey = longint'($signed(d[71:58])); ez = longint'($signed(d[87:72]));
        dx = ex - sx; dy = ey - sy; dz = ez - sz;
        n = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > n) n = (dy < 0) ? -dy : dy;
        rgb = {d[95:88], d[103:96], d[111:104]};
        pos_x = 24'(sx * 512); pos_y = 24'(sy * 512); pos_z = 32'(sz * 256);
        if (n == 0) begin
          inc_x = '0; inc_y = '0; inc_z = '0;
        end else begin
          inc_x = 24'(div_half_away(dx * 8192, n));
          inc_y = 24'(div_half_away(dy * 8192, n));
          inc_z = 32'(div_half_away(dz * 4096, n));
        end
        pts_left = 32'(((n + 15) >> 4) + 1);
        lines++;
        return;
      end
      if (pts_left == 0) return;
      xx = pixel_floor(longint'($signed(pos_x)));
      yy = pixel_floor(longint'($signed(pos_y)));
      zz = longint'($signed(pos_z));
      on = xx >= 0 && xx < SW && yy >= 0 && yy < SH;
      we = 0;
      if (on && zz < 0) begin
        inv = (64'd1 << 32) / (-zz);
        if (inv > 65535) inv = 65535;
        idx = yy * SW + xx;
        if (inv >= zbuf[idx]) begin
          zbuf[idx] = 16'(inv);
          we = 1;
        end
      end
      p.px = on ? 10'(xx) : '0;
      p.py = on ? 10'(yy) : '0;
      p.colour = {dtlr_pkg::ALPHA, rgb};
      p.we = we; p.off = !on; p.last = (pts_left == 1);
      pending_px = {pending_px, p};
      writes += we; offs += !on;
      pos_x += inc_x; pos_y += inc_y; pos_z += inc_z;
      pts_left--;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h (pixel %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_pixel(logic [55:0] d, logic [1:0] u, logic l);
      pixel_t e;
      if (pending_px.size() == 0) begin
        report("unexpected pixel word", d[31:0], '0);
        return;
      end
      e = pending_px.pop_front();
      if (d[9:0] !== e.px) report("pixel_x", 32'(d[9:0]), 32'(e.px));
      if (d[19:10] !== e.py) report("pixel_y", 32'(d[19:10]), 32'(e.py));
      if (d[51:20] !== e.colour) report("pixel_colour", d[51:20], e.colour);
      if (u[0] !== e.we) report("write_enable", 32'(u[0]), 32'(e.we));
      if (u[1] !== e.off) report("off_screen", 32'(u[1]), 32'(e.off));
      if (l !== e.last) report("last_pixel", 32'(l), 32'(e.last));
      checked++;
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_tvalid_i = 0, m_tready_i = 0;
  logic s_tuser_i = 0;
  logic [111:0] s_tdata_i = '0;
  logic m_tvalid_o, s_tready_o, m_tlast_o;
  logic [1:0] m_tuser_o;
  logic [55:0] m_tdata_o;

  raster_scoreboard sb = new();
  int sent = 0, burst_left = 0, rx_count = 0;
  bit hold_done = 0;

  always #1 clk_i = ~clk_i;

  depth_tested_line_raster_unit dut (.*);

  function automatic logic [111:0] pack_word(logic [13:0] sx, logic [13:0] sy,
      logic [15:0] sz, logic [13:0] ex, logic [13:0] ey, logic [15:0] ez,
      logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {b, g, r, ez, ey, ex, sz, sy, sx};
  endfunction

  task automatic send_word(logic act, logic [111:0] d);
    if (burst_left == 0) begin
      s_tvalid_i = 0;
      burst_left = $urandom_range(1, 30);
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    burst_left--;
    s_tvalid_i = 1;
    s_tuser_i  = act;
    s_tdata_i  = d;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_word(act, d);
    sent++;
    @(negedge clk_i);
    s_tvalid_i = 0;
  endtask

  task automatic send_tick();
    send_word(dtlr_pkg::ACT_TICK, 112'({$urandom, $urandom, $urandom, $urandom}));
  endtask

  // One start word, then enough ticks to walk the line (capped), sometimes one extra.
  task automatic draw_line(int sx, int sy, int sz, int ex, int ey, int ez,
                           logic [23:0] rgb, int cap);
    int adx, ady, n, pts;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    n = (adx > ady) ? adx : ady;
    pts = ((n + 15) >> 4) + 1;
    if (pts > cap) pts = cap;
    send_word(dtlr_pkg::ACT_START,
              pack_word(14'(sx), 14'(sy), 16'(sz), 14'(ex), 14'(ey), 16'(ez),
                        rgb[23:16], rgb[15:8], rgb[7:0]));
    repeat (pts + $urandom_range(0, 1)) send_tick();
  endtask

  function automatic int neg_depth();
    return -int'($urandom_range(1, 32768));
  endfunction

  // Receiver: random stall pattern whose density changes per phase, plus one long hold.
  initial begin
    int phase_left, stall_pct;
    phase_left = 0; stall_pct = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && rx_count >= 200) begin
        hold_done = 1;
        m_tready_i = 0;
        repeat (400) @(negedge clk_i);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      m_tready_i = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_pixel(m_tdata_o, m_tuser_o, m_tlast_o);
      rx_count++;
    end
  end

  initial begin
    #5000000;
    $display("Stopped at the time limit after %0d input words and %0d pixels checked.",
             sent, sb.checked);
    $display("depth_tested_line_raster_unit verification failed");
    $finish;
  end

  initial begin
    int sel;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: idle tick, extremes, zero length, overshoot, depth signs, abort.
    send_tick();
    draw_line(0, 0, -32768, 0, 0, -32768, 24'h000000, 4);
    draw_line(16, 16, -1, 16, 16, -1, 24'hFFFFFF, 4);
    draw_line(100, 200, -4096, 140, 208, -8192, 24'h12AB34, 8);
    draw_line(-8192, -8192, 32767, 8191, 8191, -32768, 24'hFF00FF, 6);
    draw_line(8191, -8192, 0, -8192, 8191, 0, 24'h00FF00, 4);
    draw_line(-8, 40, -2048, 40, 40, -2048, 24'h808080, 6);
    draw_line(5100, 3830, 4096, 5119, 3839, -4096, 24'h0000FF, 4);
    send_word(dtlr_pkg::ACT_START,
              pack_word(14'd32, 14'd32, -16'sd512, 14'd800, 14'd32, -16'sd512,
                        8'h11, 8'h22, 8'h33));
    send_tick();
    draw_line(32, 32, -512, 800, 32, -600, 24'h445566, 3);

    // Random part.
    while (sent < NUM_WORDS) begin
      if (sent > 1000 && sent < 1010) begin
        s_tvalid_i = 0;
        wait (sb.pending_px.size() == 0);
        @(negedge clk_i);
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        int sx, sy, ex, ey;
        sx = $urandom_range(0, 5119); sy = $urandom_range(0, 3839);
        ex = sx + int'($urandom_range(0, 960)) - 480;
        ey = sy + int'($urandom_range(0, 960)) - 480;
        if ($urandom_range(0, 9) == 0) begin
          ex = sx; ey = sy;
        end
        draw_line(sx, sy,
                  ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32767)) : neg_depth(),
                  ex, ey, neg_depth(), 24'($urandom), 40);
      end else if (sel < 95) begin
        draw_line(int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192,
                  int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192,
                  int'($urandom_range(0, 65535)) - 32768, 24'($urandom), 12);
      end else begin
        send_tick();
      end
    end
    s_tvalid_i = 0;

    wait (sb.pending_px.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d input words and %0d lines; %0d pixels checked,", sent, sb.lines,
             sb.checked);
    $display("%0d of them written and %0d off screen.", sb.writes, sb.offs);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("depth_tested_line_raster_unit verification clean");
    end else begin
      $display("depth_tested_line_raster_unit verification failed");
    end
    $finish;
  end

endmodule
